@@ rtl/core/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// Shell command tokenizer package
// Shared types, event codes, token kinds and character constants.
// ----------------------------------------------------------------------------
package sct_pkg;

   // Kind of the token that is currently open.
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_WORD   = 2'd1,
      KIND_QUOTED = 2'd2,
      KIND_OPER   = 2'd3
   } sct_kind_type;

   // Event codes on the result channel.
   localparam logic [1:0] EV_CHAR      = 2'd0;
   localparam logic [1:0] EV_CLOSE     = 2'd1;
   localparam logic [1:0] EV_LINE_DONE = 2'd2;

   // Kinds reported when a token closes.
   localparam logic [1:0] TOK_WORD   = 2'd0;
   localparam logic [1:0] TOK_QUOTED = 2'd1;
   localparam logic [1:0] TOK_OPER   = 2'd2;

   // Most events that one item can cause.
   localparam int unsigned MAX_EVENTS = 4;

   // Characters with a meaning of their own.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BTICK = 8'h60;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] token_char;
      logic [1:0] token_kind;
   } sct_event_type;

   // All events caused by one item, in order; count is 1 to MAX_EVENTS.
   typedef struct packed {
      logic [2:0]                         count;
      sct_event_type [MAX_EVENTS-1:0]     events;
   } sct_bundle_type;

   function automatic logic [1:0] close_kind(input sct_kind_type k);
      logic [1:0] r;
      r = TOK_WORD;
      case (k)
         KIND_WORD:   r = TOK_WORD;
         KIND_QUOTED: r = TOK_QUOTED;
         KIND_OPER:   r = TOK_OPER;
         default:     r = TOK_WORD;
      endcase
      return r;
   endfunction

   function automatic logic is_single_op(input logic [7:0] c);
      return (c == CH_LT) || (c == CH_GT) || (c == CH_AMP) || (c == CH_PIPE) ||
             (c == CH_SEMI) || (c == CH_BTICK);
   endfunction

   function automatic logic is_mergeable(input logic [7:0] c);
      return (c == CH_GT) || (c == CH_AMP) || (c == CH_PIPE);
   endfunction

endpackage

@@ rtl/core/shell_command_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// Shell command tokenizer core
// Turns a stream of command-line characters into token events.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Item contents
//  --------+-----------+----------------------+-----------------------------------
//  req_    | in        | req_valid / req_stall | ch, has_char, end_of_line
//  rsp_    | out       | rsp_valid / rsp_stall | event_kind, token_char,
//          |           |                      | token_kind, last
//
//  The front end takes one item per cycle while the queue is not full and turns it
//  into zero to four events in the same cycle; the queue (QUEUE_DEPTH bundles)
//  hands them to the back end. The back end drives one event per cycle from its
//  output register while rsp_stall is low, so the sustained rate is one item per
//  cycle while items average at most one event each.
//  Reset is synchronous and clears the token state, the queue and the output valid flag.
//  A stall on rsp_ fills the queue; req_stall rises only when the queue is full.
//
module shell_command_tokenizer_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_has_char,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_token_char,
   output logic [1:0] rsp_token_kind,
   output logic       rsp_last
);
   import sct_pkg::*;

   // Bundles carry every event of one item, so the queue never splits an item.
   sct_bundle_type push_data;
   sct_bundle_type head;
   logic           push;
   logic           pop;
   logic           not_empty;
   logic           full;

   // Front end: token state machine and event builder.
   sct_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_has_char    (req_has_char),
      .req_end_of_line (req_end_of_line),
      .queue_full      (full),
      .push            (push),
      .push_data       (push_data)
   );

   // Decoupling queue between the two halves.
   sct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   // Back end: serializes each bundle onto the result channel.
   sct_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (not_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_token_char (rsp_token_char),
      .rsp_token_kind (rsp_token_kind),
      .rsp_last       (rsp_last)
   );

   // The line-done event is always the final event of its item.
   a_line_done_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_LINE_DONE) |-> rsp_last)
      else $error("line-done event not marked last");

   // Only character events carry a character.
   a_char_only_on_char : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_CHAR) |-> (rsp_token_char == 8'h00))
      else $error("non-character event carries a character");

   // Only close events carry a token kind.
   a_kind_only_on_close : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_CLOSE) |-> (rsp_token_kind == TOK_WORD))
      else $error("token kind set on a non-close event");

   // The front end never pushes into a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("event bundle pushed into a full queue");

endmodule

@@ rtl/core/sct_front.sv @@
// ----------------------------------------------------------------------------
// Shell command tokenizer front end
// Accepts characters, tracks the open token and builds each item's events.
// ----------------------------------------------------------------------------
module sct_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_ch,
   input  logic                   req_has_char,
   input  logic                   req_end_of_line,
   input  logic                   queue_full,
   output logic                   push,
   output sct_pkg::sct_bundle_type push_data
);
   import sct_pkg::*;

   sct_kind_type kind_ff, kind_in;
   logic [7:0]   pend_ff, pend_in;
   logic         cmt_ff, cmt_in;
   logic         accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Walk the item's character and end marker, collecting events in order.
   always_comb begin
      sct_event_type ev [MAX_EVENTS];
      logic [2:0]    n;
      sct_kind_type  kind;
      logic [7:0]    pend;
      logic          cmt;
      logic          done;

      for (int i = 0; i < MAX_EVENTS; i++) begin
         ev[i] = '0;
      end
      n    = '0;
      kind = kind_ff;
      pend = pend_ff;
      cmt  = cmt_ff;
      done = 1'b0;

      if (req_has_char && !cmt) begin
         if (req_ch == CH_NUL) begin
            cmt = 1'b1;
         end else begin
            if (kind == KIND_OPER) begin
               if (pend == req_ch && is_mergeable(req_ch)) begin
                  ev[n[1:0]] = '{EV_CHAR, req_ch, TOK_WORD};
                  n = n + 3'd1;
                  done = 1'b1;
               end
               ev[n[1:0]] = '{EV_CLOSE, 8'h00, TOK_OPER};
               n    = n + 3'd1;
               kind = KIND_NONE;
               pend = 8'h00;
            end
            if (!done) begin
               if (req_ch == CH_QUOTE) begin
                  if (kind != KIND_NONE) begin
                     ev[n[1:0]] = '{EV_CLOSE, 8'h00, close_kind(kind)};
                     n = n + 3'd1;
                  end
                  kind = (kind == KIND_QUOTED) ? KIND_NONE : KIND_QUOTED;
                  pend = 8'h00;
               end else if (kind == KIND_QUOTED) begin
                  ev[n[1:0]] = '{EV_CHAR, req_ch, TOK_WORD};
                  n = n + 3'd1;
               end else if (is_single_op(req_ch)) begin
                  if (kind != KIND_NONE) begin
                     ev[n[1:0]] = '{EV_CLOSE, 8'h00, close_kind(kind)};
                     n = n + 3'd1;
                  end
                  kind = KIND_OPER;
                  pend = req_ch;
                  ev[n[1:0]] = '{EV_CHAR, req_ch, TOK_WORD};
                  n = n + 3'd1;
               end else if (req_ch == CH_SPACE) begin
                  if (kind != KIND_NONE) begin
                     ev[n[1:0]] = '{EV_CLOSE, 8'h00, close_kind(kind)};
                     n = n + 3'd1;
                  end
                  kind = KIND_NONE;
                  pend = 8'h00;
               end else if (kind == KIND_WORD) begin
                  ev[n[1:0]] = '{EV_CHAR, req_ch, TOK_WORD};
                  n = n + 3'd1;
               end else if (req_ch == CH_HASH) begin
                  cmt = 1'b1;
               end else begin
                  kind = KIND_WORD;
                  ev[n[1:0]] = '{EV_CHAR, req_ch, TOK_WORD};
                  n = n + 3'd1;
               end
            end
         end
      end

      if (req_end_of_line) begin
         if (kind != KIND_NONE) begin
            ev[n[1:0]] = '{EV_CLOSE, 8'h00, close_kind(kind)};
            n = n + 3'd1;
         end
         ev[n[1:0]] = '{EV_LINE_DONE, 8'h00, TOK_WORD};
         n    = n + 3'd1;
         kind = KIND_NONE;
         pend = 8'h00;
         cmt  = 1'b0;
      end

      kind_in = kind;
      pend_in = pend;
      cmt_in  = cmt;
      push_data.count = n;
      for (int i = 0; i < MAX_EVENTS; i++) begin
         push_data.events[i] = ev[i];
      end
      push = accept && (n != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_NONE;
         pend_ff <= 8'h00;
         cmt_ff  <= 1'b0;
      end else if (accept) begin
         kind_ff <= kind_in;
         pend_ff <= pend_in;
         cmt_ff  <= cmt_in;
      end
   end

endmodule

@@ rtl/core/sct_queue.sv @@
// ----------------------------------------------------------------------------
// Shell command tokenizer event queue
// Small FIFO of per-item event bundles between front and back end.
// ----------------------------------------------------------------------------
module sct_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sct_pkg::sct_bundle_type push_data,
   input  logic                   pop,
   output sct_pkg::sct_bundle_type head,
   output logic                   not_empty,
   output logic                   full
);
   import sct_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   sct_bundle_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/sct_back.sv @@
// ----------------------------------------------------------------------------
// Shell command tokenizer back end
// Plays out each bundle one event per cycle, while rsp_stall is low, into the result register.
// ----------------------------------------------------------------------------
module sct_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sct_pkg::sct_bundle_type head,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_event_kind,
   output logic [7:0]             rsp_token_char,
   output logic [1:0]             rsp_token_kind,
   output logic                   rsp_last
);
   import sct_pkg::*;

   logic [1:0]    idx_ff, idx_in;
   logic          valid_ff, valid_in;
   sct_event_type ev_ff, ev_in;
   logic          last_ff, last_in;
   logic          load, is_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign is_last = (({1'b0, idx_ff} + 3'd1) == head.count);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      ev_in    = ev_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         ev_in    = head.events[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_event_kind = ev_ff.event_kind;
   assign rsp_token_char = ev_ff.token_char;
   assign rsp_token_kind = ev_ff.token_kind;
   assign rsp_last       = last_ff;

endmodule
